### rtl/sie_pkg.sv
package sie_pkg;

	localparam int COORD_W = 20;
	localparam int COUNT_W = 13;
	localparam int VALUE_W = 32;
	localparam int MAG_W = 20;
	localparam int SUM_W = 62;
	localparam int F_W = 48;
	localparam int EXP_TERMS = 13;
	localparam int K_BIAS = 47;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	localparam value_t SAT_POS = 32'sh7FFFFFFF;
	localparam value_t SAT_NEG = 32'sh80000000;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_RUN = 2'd0,
		CMD_BAD = 2'd1,
		CMD_ZERO = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		coord_t a;
		logic neg;
		mag_t ad;
		count_t n;
	} cmd_t;

	function automatic logic [32:0] recip(input logic [3:0] j);
		logic [32:0] r;
		unique case (j)
			4'd1: r = 33'd4294967296;
			4'd2: r = 33'd2147483648;
			4'd3: r = 33'd1431655765;
			4'd4: r = 33'd1073741824;
			4'd5: r = 33'd858993459;
			4'd6: r = 33'd715827882;
			4'd7: r = 33'd613566756;
			4'd8: r = 33'd536870912;
			4'd9: r = 33'd477218588;
			4'd10: r = 33'd429496729;
			4'd11: r = 33'd390451572;
			4'd12: r = 33'd357913941;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/sie_if.sv
interface sie_in_if import sie_pkg::*; ();
	logic valid;
	logic ready;
	coord_t lower_limit;
	coord_t upper_limit;
	count_t interval_count;
	modport source (output valid, lower_limit, upper_limit, interval_count, input ready);
	modport sink (input valid, lower_limit, upper_limit, interval_count, output ready);
endinterface

interface sie_out_if import sie_pkg::*; ();
	logic valid;
	logic ready;
	value_t integral_value;
	status_t status;
	modport source (output valid, integral_value, status, input ready);
	modport sink (input valid, integral_value, status, output ready);
endinterface

### rtl/simpson_integral_exp2x.sv
// Composite Simpson integral of e^(2x) over [lower_limit, upper_limit].
// Channel job (sink): lower_limit, upper_limit (signed Q4.16) and an even
// interval_count; an item moves when valid and ready are both high.
// Channel result (source): integral_value (signed Q16.16, saturated) and
// status (ok, bad count, saturated); one result item per job item.
// A two-entry queue parts the front classifier from the back sequencer, so
// up to two job items are taken while a result is being computed.
// A bad count or equal limits skips all computation and goes straight to the
// emit state. Otherwise the job runs the step division, then each sample point
// in the shared exponential unit (7 reduction steps, 12 series terms each
// through a multiply, reciprocal and fix-up state, plus start and hand-back),
// then two passes of the serial divider for the final scaling. Points outside
// the exponent range skip the reduction and series; an exponent overflow skips
// the final scaling. One item is worked on at a time; the sequencer takes the
// next job item only once the result has been handed to the output register.
// Reset clears the queue, the sequencer and the output valid at once.
// While the receiver stalls the result item is held; the next result waits
// in the sequencer, and job ready falls once the queue is full.
module simpson_integral_exp2x import sie_pkg::*; #(
	parameter int MAX_INTERVALS = 4096,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	sie_in_if.sink job,
	sie_out_if.source result
);

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	sie_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
		.job(job),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	sie_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	sie_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.result(result)
	);

`ifndef ASSERT_OFF
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> pop_valid)
		else $error("pushed item missing from queue");
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> pop_valid)
		else $error("queue full yet empty");
`endif

endmodule

### rtl/sie_front.sv
module sie_front import sie_pkg::*; #(
	parameter int MAX_INTERVALS = 4096
) (
	sie_in_if.sink job,
	output logic push_valid,
	input logic push_ready,
	output cmd_t push_data
);

	logic signed [COORD_W:0] d;
	logic bad;

	always_comb begin
		d = {job.upper_limit[COORD_W-1], job.upper_limit}
			- {job.lower_limit[COORD_W-1], job.lower_limit};
		bad = (job.interval_count == '0) || job.interval_count[0]
			|| (int'(job.interval_count) > MAX_INTERVALS);
		push_data.a = job.lower_limit;
		push_data.n = job.interval_count;
		push_data.neg = d[COORD_W];
		push_data.ad = d[COORD_W] ? mag_t'(-d) : mag_t'(d);
		priority if (bad) begin
			push_data.kind = CMD_BAD;
		end else if (d == '0) begin
			push_data.kind = CMD_ZERO;
		end else begin
			push_data.kind = CMD_RUN;
		end
	end

	assign push_valid = job.valid;
	assign job.ready = push_ready;

endmodule

### rtl/sie_queue.sv
module sie_queue import sie_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input cmd_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output cmd_t pop_data
);

	cmd_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = ent_q[rd_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_fire) wr_q <= ~wr_q;
			if (pop_fire) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push_fire) - 2'(pop_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) ent_q[wr_q] <= push_data;
	end

endmodule

### rtl/sie_div.sv
module sie_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [14:0] divisor,
	output logic done,
	output logic [63:0] quot,
	output logic [14:0] rem
);

	logic [63:0] num_q;
	logic [14:0] rem_q;
	logic [14:0] div_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [15:0] trial;
	logic fits;

	always_comb begin
		trial = {rem_q, num_q[63]};
		fits = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			rem_q <= '0;
			div_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], fits};
				rem_q <= fits ? 15'(trial - {1'b0, div_q}) : trial[14:0];
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem = rem_q;

endmodule

### rtl/sie_exp.sv
module sie_exp import sie_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input coord_t x,
	output logic done,
	output logic over,
	output logic [F_W-1:0] f
);

	localparam int TW = 44;
	localparam int RW = 37;
	localparam logic signed [TW-1:0] T_HI = 44'sd17179869184;
	localparam logic signed [TW-1:0] T_LO = -44'sd34359738368;
	localparam logic signed [TW-1:0] T_BIAS = 44'sd34980272546;
	localparam logic [6:0] K_SHIFT = 7'(K_BIAS + 6);

	typedef enum logic [5:0] {
		E_IDLE = 6'b000001,
		E_RED = 6'b000010,
		E_MUL = 6'b000100,
		E_RCP = 6'b001000,
		E_FIX = 6'b010000,
		E_SCL = 6'b100000
	} exp_state_t;

	exp_state_t state_q;
	logic signed [TW-1:0] t;
	logic signed [TW-1:0] tb;
	logic [RW-1:0] tt_q;
	logic [RW-1:0] ln2_sh;
	logic [6:0] k_q;
	logic [2:0] j_q;
	logic [3:0] n_q;
	logic [30:0] term_q;
	logic [30:0] v_q;
	logic [30:0] q0;
	logic [30:0] chk;
	logic [30:0] tnext;
	logic [31:0] sum_q;
	logic [60:0] prod_q;
	logic [63:0] qm_q;
	logic [63:0] up;
	logic [63:0] dn;
	logic [5:0] sh;
	logic [F_W-1:0] fnext;
	logic [F_W-1:0] f_q;
	logic done_q;
	logic over_q;

	always_comb begin
		t = TW'(x) <<< (31 - FRAC_BITS);
		tb = t + T_BIAS;
		ln2_sh = RW'(LN2_Q30) << j_q;
		q0 = qm_q[62:32];
		chk = v_q - 31'(q0 * n_q);
		tnext = (chk >= 31'(n_q)) ? q0 + 31'd1 : q0;
		up = 64'(sum_q) << (k_q - K_SHIFT);
		sh = 6'(K_SHIFT - k_q);
		dn = (64'(sum_q) + (64'd1 << (sh - 6'd1))) >> sh;
		fnext = (k_q >= K_SHIFT) ? up[F_W-1:0] : dn[F_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			tt_q <= '0;
			k_q <= '0;
			j_q <= '0;
			n_q <= '0;
			term_q <= '0;
			v_q <= '0;
			sum_q <= '0;
			prod_q <= '0;
			qm_q <= '0;
			f_q <= '0;
			done_q <= 1'b0;
			over_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						priority if (t > T_HI) begin
							f_q <= '0;
							over_q <= 1'b1;
							done_q <= 1'b1;
						end else if (t < T_LO) begin
							f_q <= '0;
							over_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							tt_q <= tb[RW-1:0];
							k_q <= '0;
							j_q <= 3'd6;
							state_q <= E_RED;
						end
					end
				end
				E_RED: begin
					if (tt_q >= ln2_sh) begin
						tt_q <= tt_q - ln2_sh;
						k_q[j_q] <= 1'b1;
					end
					if (j_q == 3'd0) begin
						term_q <= 31'd1 << 30;
						sum_q <= 32'd1 << 30;
						n_q <= 4'd1;
						state_q <= E_MUL;
					end else begin
						j_q <= j_q - 3'd1;
					end
				end
				E_MUL: begin
					prod_q <= term_q * tt_q[29:0];
					state_q <= E_RCP;
				end
				E_RCP: begin
					v_q <= prod_q[60:30];
					qm_q <= prod_q[60:30] * recip(n_q);
					state_q <= E_FIX;
				end
				E_FIX: begin
					term_q <= tnext;
					sum_q <= sum_q + 32'(tnext);
					if (n_q == 4'(EXP_TERMS - 1)) begin
						state_q <= E_SCL;
					end else begin
						n_q <= n_q + 4'd1;
						state_q <= E_MUL;
					end
				end
				E_SCL: begin
					f_q <= fnext;
					over_q <= 1'b0;
					done_q <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign over = over_q;
	assign f = f_q;

endmodule

### rtl/sie_back.sv
module sie_back import sie_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input cmd_t pop_data,
	sie_out_if.source result
);

	typedef enum logic [12:0] {
		B_IDLE = 13'b0000000000001,
		B_HGO = 13'b0000000000010,
		B_HDIV = 13'b0000000000100,
		B_PNT = 13'b0000000001000,
		B_EXPW = 13'b0000000010000,
		B_SGO = 13'b0000000100000,
		B_SDIV = 13'b0000001000000,
		B_MUL1 = 13'b0000010000000,
		B_MUL2 = 13'b0000100000000,
		B_RGO = 13'b0001000000000,
		B_RDIV = 13'b0010000000000,
		B_FIN = 13'b0100000000000,
		B_EMIT = 13'b1000000000000
	} back_state_t;

	back_state_t state_q;
	cmd_t cmd_q;
	count_t i_q;
	mag_t off_q;
	mag_t qd_q;
	count_t remd_q;
	count_t rd_q;
	logic [SUM_W-1:0] s_q;
	logic over_q;
	logic [63:0] quo_q;
	logic [14:0] rem_q;
	logic [50:0] lo_q;
	logic [52:0] hi_q;
	logic [34:0] ra_q;
	logic [63:0] pm_q;
	value_t res_val_q;
	status_t res_st_q;
	logic ov_q;
	value_t out_val_q;
	status_t out_st_q;

	logic [14:0] n3;
	logic [13:0] remd_n;
	logic signed [COORD_W:0] xw;
	coord_t x;
	logic [SUM_W-1:0] fw;
	logic [83:0] full;
	logic [63:0] mag;
	logic emit_fire;

	logic dv_start;
	logic [63:0] dv_dividend;
	logic [14:0] dv_divisor;
	logic dv_done;
	logic [63:0] dv_quot;
	logic [14:0] dv_rem;
	logic ex_start;
	logic ex_done;
	logic ex_over;
	logic [F_W-1:0] ex_f;

	sie_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.dividend(dv_dividend),
		.divisor(dv_divisor),
		.done(dv_done),
		.quot(dv_quot),
		.rem(dv_rem)
	);

	sie_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.start(ex_start),
		.x(x),
		.done(ex_done),
		.over(ex_over),
		.f(ex_f)
	);

	always_comb begin
		n3 = 15'(cmd_q.n) + 15'({cmd_q.n, 1'b0});
		remd_n = 14'(remd_q) + 14'(rd_q);
		xw = cmd_q.neg ? {cmd_q.a[COORD_W-1], cmd_q.a} - {1'b0, off_q}
			: {cmd_q.a[COORD_W-1], cmd_q.a} + {1'b0, off_q};
		x = xw[COORD_W-1:0];
		priority if (i_q == '0 || i_q == cmd_q.n) begin
			fw = SUM_W'(ex_f);
		end else if (i_q[0]) begin
			fw = SUM_W'(ex_f) << 2;
		end else begin
			fw = SUM_W'(ex_f) << 1;
		end
		full = {hi_q, 31'b0} + 84'(lo_q);
		mag = (pm_q + 64'd8388608) >> 24;
		dv_start = (state_q == B_HGO) || (state_q == B_SGO) || (state_q == B_RGO);
		priority if (state_q == B_HGO) begin
			dv_dividend = 64'(cmd_q.ad);
			dv_divisor = 15'(cmd_q.n);
		end else if (state_q == B_SGO) begin
			dv_dividend = 64'(s_q);
			dv_divisor = n3;
		end else begin
			dv_dividend = 64'(ra_q);
			dv_divisor = n3;
		end
		ex_start = (state_q == B_PNT);
		pop_ready = (state_q == B_IDLE);
		emit_fire = (state_q == B_EMIT) && (!ov_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cmd_q <= '0;
			i_q <= '0;
			off_q <= '0;
			qd_q <= '0;
			remd_q <= '0;
			rd_q <= '0;
			s_q <= '0;
			over_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			ra_q <= '0;
			pm_q <= '0;
			res_val_q <= '0;
			res_st_q <= ST_OK;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						cmd_q <= pop_data;
						res_val_q <= '0;
						unique case (pop_data.kind)
							CMD_BAD: begin
								res_st_q <= ST_BAD_COUNT;
								state_q <= B_EMIT;
							end
							CMD_ZERO: begin
								res_st_q <= ST_OK;
								state_q <= B_EMIT;
							end
							CMD_RUN: state_q <= B_HGO;
							default: state_q <= B_IDLE;
						endcase
					end
				end
				B_HGO: state_q <= B_HDIV;
				B_HDIV: begin
					if (dv_done) begin
						qd_q <= dv_quot[MAG_W-1:0];
						rd_q <= dv_rem[COUNT_W-1:0];
						i_q <= '0;
						off_q <= '0;
						remd_q <= '0;
						s_q <= '0;
						over_q <= 1'b0;
						state_q <= B_PNT;
					end
				end
				B_PNT: state_q <= B_EXPW;
				B_EXPW: begin
					if (ex_done) begin
						s_q <= s_q + fw;
						over_q <= over_q | ex_over;
						if (i_q == cmd_q.n) begin
							if (over_q || ex_over) begin
								res_val_q <= cmd_q.neg ? SAT_NEG : SAT_POS;
								res_st_q <= ST_SAT;
								state_q <= B_EMIT;
							end else begin
								state_q <= B_SGO;
							end
						end else begin
							i_q <= i_q + 1'b1;
							if (remd_n >= 14'(cmd_q.n)) begin
								remd_q <= COUNT_W'(remd_n - 14'(cmd_q.n));
								off_q <= off_q + qd_q + 1'b1;
							end else begin
								remd_q <= COUNT_W'(remd_n);
								off_q <= off_q + qd_q;
							end
							state_q <= B_PNT;
						end
					end
				end
				B_SGO: state_q <= B_SDIV;
				B_SDIV: begin
					if (dv_done) begin
						quo_q <= dv_quot;
						rem_q <= dv_rem;
						state_q <= B_MUL1;
					end
				end
				B_MUL1: begin
					lo_q <= quo_q[30:0] * cmd_q.ad;
					hi_q <= quo_q[63:31] * cmd_q.ad;
					ra_q <= rem_q * cmd_q.ad;
					state_q <= B_MUL2;
				end
				B_MUL2: begin
					if (full[83:62] != '0) begin
						res_val_q <= cmd_q.neg ? SAT_NEG : SAT_POS;
						res_st_q <= ST_SAT;
						state_q <= B_EMIT;
					end else begin
						pm_q <= 64'(full[61:0]);
						state_q <= B_RGO;
					end
				end
				B_RGO: state_q <= B_RDIV;
				B_RDIV: begin
					if (dv_done) begin
						pm_q <= pm_q + dv_quot;
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if ((cmd_q.neg && mag > 64'h80000000)
						|| (!cmd_q.neg && mag > 64'h7FFFFFFF)) begin
						res_val_q <= cmd_q.neg ? SAT_NEG : SAT_POS;
						res_st_q <= ST_SAT;
					end else begin
						res_val_q <= cmd_q.neg ? -value_t'(mag[31:0]) : value_t'(mag[31:0]);
						res_st_q <= ST_OK;
					end
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (emit_fire) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_fire) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_val_q <= res_val_q;
			out_st_q <= res_st_q;
		end
	end

	assign result.valid = ov_q;
	assign result.integral_value = out_val_q;
	assign result.status = out_st_q;

endmodule

### tb/tb_top.sv
module tb_top;
	import sie_pkg::*;

	localparam int FRAC = 16;
	localparam int MAX_N = 4096;
	localparam longint LN2 = 64'sd744261118;
	localparam int STALL_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		value_t value;
		status_t status;
	} integral_t;

	logic clk = 1'b0;
	logic arst_n;
	bit calm;
	int stall_cycles;
	int jobs_sent;
	int results_seen;
	int mismatches;
	int saturated_seen;
	int bad_count_seen;
	integral_t pending_results[$];

	sie_in_if job_ch();
	sie_out_if res_ch();

	simpson_integral_exp2x #(.MAX_INTERVALS(MAX_N), .FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_ch),
		.result(res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] exp2x_q24(input longint x, inout bit over);
		longint t;
		longint k;
		longint r;
		longint s;
		logic [63:0] term;
		logic [63:0] sum;
		t = x * 2 * (64'sd1 <<< (30 - FRAC));
		if (t > (64'sd16 <<< 30)) begin
			over = 1'b1;
			return 64'd0;
		end
		if (t < -(64'sd32 <<< 30))
			return 64'd0;
		k = t / LN2;
		if (k * LN2 > t)
			k--;
		r = t - k * LN2;
		term = 64'd1 << 30;
		sum = term;
		for (int j = 1; j < 13; j++) begin
			term = ((term * 64'(r)) >> 30) / 64'(j);
			sum += term;
		end
		s = k - 6;
		if (s >= 0)
			return sum << s;
		s = -s;
		return (sum + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic integral_t predict_integral(input coord_t a, input coord_t b,
			input count_t n);
		integral_t res;
		longint sa;
		longint d;
		longint x;
		logic [63:0] ad;
		logic [63:0] sum;
		logic [63:0] off;
		logic [63:0] w;
		logic [63:0] div;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] p;
		logic [63:0] mag;
		bit over;
		res.value = '0;
		res.status = ST_OK;
		sa = a;
		d = longint'(b) - sa;
		over = 1'b0;
		sum = '0;
		if (n == 0 || n[0] || n > MAX_N) begin
			res.status = ST_BAD_COUNT;
			return res;
		end
		if (d == 0)
			return res;
		ad = d < 0 ? 64'(-d) : 64'(d);
		for (int i = 0; i <= n; i++) begin
			off = (64'(i) * ad) / 64'(n);
			x = d < 0 ? sa - longint'(off) : sa + longint'(off);
			w = (i == 0 || i == n) ? 64'd1 : (i % 2 == 1 ? 64'd4 : 64'd2);
			sum += w * exp2x_q24(x, over);
		end
		if (!over) begin
			div = 64'd3 * 64'(n);
			q = sum / div;
			rem = sum % div;
			if (q > ((64'd1 << 62) - 64'd1) / ad) begin
				over = 1'b1;
			end else begin
				p = q * ad + (rem * ad) / div;
				mag = (p + (64'd1 << 23)) >> 24;
				if (d > 0 && mag > 64'h7FFFFFFF)
					over = 1'b1;
				else if (d < 0 && mag > 64'h80000000)
					over = 1'b1;
				else
					res.value = d > 0 ? value_t'(mag) : value_t'(-mag);
			end
		end
		if (over) begin
			res.value = d > 0 ? SAT_POS : SAT_NEG;
			res.status = ST_SAT;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
	end

	always @(posedge clk) begin
		integral_t want;
		if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without an item", stall_cycles);
			$display("tb_top failed");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (res_ch.status == ST_SAT)
				saturated_seen++;
			if (res_ch.status == ST_BAD_COUNT)
				bad_count_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d status=%0d",
						res_ch.integral_value, res_ch.status);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.integral_value !== want.value || res_ch.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected value=%0d status=%0d, got value=%0d status=%0d",
							results_seen, want.value, want.status,
							res_ch.integral_value, res_ch.status);
				end
			end
		end
	end

	task automatic send_job(input coord_t a, input coord_t b, input count_t n);
		while (!calm && $urandom_range(0, 99) < 19) begin
			job_ch.valid <= 1'b0;
			@(posedge clk);
		end
		job_ch.valid <= 1'b1;
		job_ch.lower_limit <= a;
		job_ch.upper_limit <= b;
		job_ch.interval_count <= n;
		do
			@(posedge clk);
		while (!job_ch.ready);
		pending_results.push_back(predict_integral(a, b, n));
		jobs_sent++;
	endtask

	task automatic test_bad_counts();
		send_job(-20'sd65536, 20'sd65536, 13'd0);
		send_job(-20'sd65536, 20'sd65536, 13'd3);
		send_job(-20'sd65536, 20'sd65536, 13'd4098);
		send_job(20'sd0, 20'sd65536, 13'd8191);
		send_job(20'sd0, 20'sd65536, 13'd8190);
	endtask

	task automatic test_limits();
		send_job(20'sd32768, 20'sd32768, 13'd2);
		send_job(-20'sd262144, -20'sd262144, 13'd8);
		send_job(-20'sd262144, 20'sd262144, 13'd2);
		send_job(20'sd262144, -20'sd262144, 13'd16);
		send_job(20'sd0, 20'sd65536, 13'd2);
		send_job(20'sd65536, 20'sd0, 13'd10);
		send_job(20'sd0, 20'sd1, 13'd2);
		send_job(20'sd1, 20'sd0, 13'd6);
	endtask

	task automatic test_field_extremes();
		send_job(-20'sd524288, 20'sd524287, 13'd2);
		send_job(20'sd524287, -20'sd524288, 13'd4);
		send_job(20'sd327680, 20'sd524287, 13'd12);
		send_job(-20'sd524288, -20'sd400000, 13'd8);
		send_job(-20'sd524288, -20'sd500000, 13'd2);
		send_job(20'sd524287, 20'sd524286, 13'd2);
		send_job(-20'sd262144, 20'sd262144, 13'd4096);
	endtask

	task automatic test_random_jobs(input int count);
		coord_t a;
		coord_t b;
		count_t n;
		for (int k = 0; k < count; k++) begin
			calm = k >= count / 3 && k < count / 2;
			if ($urandom_range(0, 99) < 80) begin
				a = coord_t'($urandom_range(0, 524288)) - 20'sd262144;
				b = coord_t'($urandom_range(0, 524288)) - 20'sd262144;
				n = count_t'(2 * $urandom_range(1, 32));
			end else begin
				a = coord_t'($urandom);
				b = coord_t'($urandom);
				n = count_t'($urandom);
				if (n <= MAX_N && n > 128)
					n[0] = 1'b1;
			end
			send_job(a, b, n);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		job_ch.valid = 1'b0;
		job_ch.lower_limit = '0;
		job_ch.upper_limit = '0;
		job_ch.interval_count = '0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_counts();
		test_limits();
		test_field_extremes();
		test_random_jobs(80);
		job_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d jobs sent, %0d results checked (%0d saturated, %0d bad count)",
			jobs_sent, results_seen, saturated_seen, bad_count_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

### filelist.f
rtl/sie_pkg.sv
rtl/sie_if.sv
rtl/sie_front.sv
rtl/sie_queue.sv
rtl/sie_div.sv
rtl/sie_exp.sv
rtl/sie_back.sv
rtl/simpson_integral_exp2x.sv
tb/tb_top.sv
